/* src/load_store_unit_acc_mar_core_defines.svh */
// Assertion macros for the load/store unit core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LOAD_STORE_UNIT_ACC_MAR_CORE_DEFINES_SVH
`define LOAD_STORE_UNIT_ACC_MAR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LSUAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSUAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lsuam_pkg.sv */
// Shared types and constants for the load/store unit core.
// No dependencies; imported by the decoder and the top level.
`default_nettype none

package lsuam_pkg;

   // Opcode bit positions
   localparam int unsigned LOAD_BIT = 3;
   localparam int unsigned MAR_BIT  = 2;

   // Instruction lengths in bytes
   localparam logic [1:0] LEN_PRELOAD = 2'd0;
   localparam logic [1:0] LEN_SHORT   = 2'd1;
   localparam logic [1:0] LEN_ACC_IMM = 2'd2;
   localparam logic [1:0] LEN_LONG    = 2'd3;

   typedef enum logic [1:0] {
      MODE_DIRECT    = 2'd0,
      MODE_IMMEDIATE = 2'd1,
      MODE_INDIRECT  = 2'd2,
      MODE_UNUSED    = 2'd3
   } lsuam_mode_type;

   // Decoded control for one request
   typedef struct packed {
      logic        read_byte;
      logic        read_pair;
      logic        write_byte;
      logic        write_pair;
      logic        acc_imm;
      logic        mar_imm;
      logic        invalid;
      logic [1:0]  bytes_used;
      logic [15:0] addr;
      logic [7:0]  wbyte;
   } lsuam_ctl_type;

endpackage

`default_nettype wire

/* src/lsuam_decode.sv */
// Instruction decoder: turns one request into memory and register controls.
// Depends on lsuam_pkg.
`default_nettype none

module lsuam_decode
   import lsuam_pkg::*;
(
   input  wire logic          func,
   input  wire logic [7:0]    opcode_byte,
   input  wire logic [15:0]   following_bytes,
   input  wire logic [15:0]   load_address,
   input  wire logic [7:0]    load_data,
   input  wire logic [7:0]    acc,
   input  wire logic [15:0]   mar,
   output lsuam_ctl_type      ctl
);

   logic           is_load;
   logic           is_mar;
   lsuam_mode_type mode;

   assign is_load = opcode_byte[LOAD_BIT];
   assign is_mar  = opcode_byte[MAR_BIT];
   assign mode    = lsuam_mode_type'(opcode_byte[1:0]);

   always_comb begin
      ctl = '0;
      if (func) begin
         ctl.write_byte = 1'b1;
         ctl.addr       = load_address;
         ctl.wbyte      = load_data;
         ctl.bytes_used = LEN_PRELOAD;
      end else begin
         case (mode)
            MODE_DIRECT, MODE_INDIRECT: begin
               ctl.addr       = (mode == MODE_DIRECT) ? following_bytes : mar;
               ctl.bytes_used = (mode == MODE_DIRECT) ? LEN_LONG : LEN_SHORT;
               ctl.wbyte      = acc;
               ctl.read_pair  = is_mar && is_load;
               ctl.write_pair = is_mar && !is_load;
               ctl.read_byte  = !is_mar && is_load;
               ctl.write_byte = !is_mar && !is_load;
            end
            MODE_IMMEDIATE: begin
               if (!is_load) begin
                  // store to a constant is not an instruction
                  ctl.invalid    = 1'b1;
                  ctl.bytes_used = LEN_SHORT;
               end else if (is_mar) begin
                  ctl.mar_imm    = 1'b1;
                  ctl.bytes_used = LEN_LONG;
               end else begin
                  ctl.acc_imm    = 1'b1;
                  ctl.bytes_used = LEN_ACC_IMM;
               end
            end
            default: begin
               ctl.invalid    = 1'b1;
               ctl.bytes_used = LEN_SHORT;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* src/lsuam_ram.sv */
// Single-port byte RAM bank with registered read data.
// No dependencies.
`default_nettype none

module lsuam_ram #(
   parameter int unsigned DEPTH_BITS = 15
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic                  we,
   input  wire logic [DEPTH_BITS-1:0] addr,
   input  wire logic [7:0]            wdata,
   output logic      [7:0]            rdata
);

   logic [7:0] mem [2**DEPTH_BITS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/load_store_unit_acc_mar_core.sv */
// Load/store unit core: ACC/MAR registers, banked byte memory, request handling.
// Depends on lsuam_pkg, lsuam_decode, lsuam_ram and the assertion macro header.
//
// Usage:
//   Request channel (req_*): one instruction (req_func = 0) or one preload
//   byte write (req_func = 1) per request. Response channel (rsp_*): exactly
//   one response per request, in order, carrying bytes used, ACC, MAR and
//   the invalid flag after that request.
//   Each request is held in the request register for an access phase, in
//   which the memory is accessed, then a retire phase, which takes the
//   registered read data and updates ACC/MAR. A new request is not taken
//   before the previous one retires; it is taken in the same cycle the
//   previous one retires.
//   Memory is split into even and odd byte banks, so both bytes of a MAR
//   pair (A and A+1) are read or written together, one per bank.
//   Reset: ACC and MAR clear at once; then a clearing pass zeroes the memory,
//   one row of both banks per cycle, over all 2**(ADDR_BITS-1) rows (32768 at
//   the default). req_ready stays low during the pass.
//   Stall: a valid response holds while rsp_ready is low; one more request
//   may finish its memory access and then waits, and req_ready drops.
`default_nettype none
`include "load_store_unit_acc_mar_core_defines.svh"

module load_store_unit_acc_mar_core
   import lsuam_pkg::*;
#(
   parameter int unsigned ADDR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_opcode_byte,
   input  wire logic [15:0] req_following_bytes,
   input  wire logic [15:0] req_load_address,
   input  wire logic [7:0]  req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_bytes_used,
   output logic [7:0]       rsp_acc_value,
   output logic [15:0]      rsp_mar_value,
   output logic             rsp_invalid_op
);

   localparam int unsigned ROW_BITS = ADDR_BITS - 1;

   // Request register
   logic        s1_valid_ff, s1_valid_in;
   logic        phase_ff, phase_in;
   logic        func_ff;
   logic [7:0]  opcode_ff;
   logic [15:0] follow_ff;
   logic [15:0] laddr_ff;
   logic [7:0]  ldata_ff;

   // Architectural state
   logic [7:0]  acc_ff, acc_in;
   logic [15:0] mar_ff, mar_in;

   // Clearing pass
   logic                clear_active_ff;
   logic [ROW_BITS-1:0] clr_row_ff;

   // Response register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_used_ff;
   logic [7:0]  rsp_acc_ff;
   logic [15:0] rsp_mar_ff;
   logic        rsp_bad_ff;

   lsuam_ctl_type ctl;
   logic          accept;
   logic          retire;
   logic          access;
   logic [15:0]   addr_p1;
   logic [ROW_BITS-1:0] row_a, row_b;
   logic          a_odd;
   logic [7:0]    pair_hi, pair_lo;
   logic [7:0]    even_rd, odd_rd;
   logic          even_en, even_we, odd_en, odd_we;
   logic [ROW_BITS-1:0] even_addr, odd_addr;
   logic [7:0]    even_wd, odd_wd;
   logic [7:0]    rd_byte;
   logic [15:0]   rd_pair;

   lsuam_decode u_decode (
      .func            (func_ff),
      .opcode_byte     (opcode_ff),
      .following_bytes (follow_ff),
      .load_address    (laddr_ff),
      .load_data       (ldata_ff),
      .acc             (acc_ff),
      .mar             (mar_ff),
      .ctl             (ctl)
   );

   // Handshake: retire in the second phase once the response slot frees up.
   assign retire    = s1_valid_ff && phase_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_active_ff && (!s1_valid_ff || retire);
   assign accept    = req_valid && req_ready;
   assign access    = s1_valid_ff && !phase_ff;

   // Drop the phase back to access when the held request retires.
   assign s1_valid_in = accept || (s1_valid_ff && !retire);
   assign phase_in    = accept ? 1'b0 : (access ? 1'b1 : (retire ? 1'b0 : phase_ff));

   // Bank addressing: address A+1 wraps at 16 bits, then keeps ADDR_BITS bits.
   assign addr_p1 = ctl.addr + 16'd1;
   assign row_a   = ctl.addr[ADDR_BITS-1:1];
   assign row_b   = addr_p1[ADDR_BITS-1:1];
   assign a_odd   = ctl.addr[0];
   assign pair_hi = mar_ff[15:8];
   assign pair_lo = mar_ff[7:0];

   always_comb begin
      if (clear_active_ff) begin
         even_en   = 1'b1;
         even_we   = 1'b1;
         even_addr = clr_row_ff;
         even_wd   = '0;
         odd_en    = 1'b1;
         odd_we    = 1'b1;
         odd_addr  = clr_row_ff;
         odd_wd    = '0;
      end else begin
         // the even bank holds A+1 when A is odd
         even_addr = (ctl.read_pair || ctl.write_pair) && a_odd ? row_b : row_a;
         odd_addr  = row_a;
         even_en   = access && (ctl.read_pair || ctl.write_pair
                     || ((ctl.read_byte || ctl.write_byte) && !a_odd));
         odd_en    = access && (ctl.read_pair || ctl.write_pair
                     || ((ctl.read_byte || ctl.write_byte) && a_odd));
         even_we   = ctl.write_pair || ctl.write_byte;
         odd_we    = ctl.write_pair || ctl.write_byte;
         even_wd   = ctl.write_pair ? (a_odd ? pair_lo : pair_hi) : ctl.wbyte;
         odd_wd    = ctl.write_pair ? (a_odd ? pair_hi : pair_lo) : ctl.wbyte;
      end
   end

   lsuam_ram #(.DEPTH_BITS(ROW_BITS)) u_ram_even (
      .clock (clock),
      .en    (even_en),
      .we    (even_we),
      .addr  (even_addr),
      .wdata (even_wd),
      .rdata (even_rd)
   );

   lsuam_ram #(.DEPTH_BITS(ROW_BITS)) u_ram_odd (
      .clock (clock),
      .en    (odd_en),
      .we    (odd_we),
      .addr  (odd_addr),
      .wdata (odd_wd),
      .rdata (odd_rd)
   );

   // Second phase: combine read data, update ACC and MAR.
   assign rd_byte = a_odd ? odd_rd : even_rd;
   assign rd_pair = a_odd ? {odd_rd, even_rd} : {even_rd, odd_rd};

   always_comb begin
      acc_in = acc_ff;
      mar_in = mar_ff;
      if (ctl.read_byte) begin
         acc_in = rd_byte;
      end else if (ctl.acc_imm) begin
         acc_in = follow_ff[15:8];
      end
      if (ctl.read_pair) begin
         mar_in = rd_pair;
      end else if (ctl.mar_imm) begin
         mar_in = follow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         phase_ff        <= 1'b0;
         acc_ff          <= '0;
         mar_ff          <= '0;
         clear_active_ff <= 1'b1;
         clr_row_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         phase_ff    <= phase_in;
         if (clear_active_ff) begin
            clr_row_ff <= clr_row_ff + 1'b1;
            if (&clr_row_ff) begin
               clear_active_ff <= 1'b0;
            end
         end
         if (retire) begin
            acc_ff       <= acc_in;
            mar_ff       <= mar_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         opcode_ff <= req_opcode_byte;
         follow_ff <= req_following_bytes;
         laddr_ff  <= req_load_address;
         ldata_ff  <= req_load_data;
      end
      if (retire) begin
         rsp_used_ff <= ctl.bytes_used;
         rsp_acc_ff  <= acc_in;
         rsp_mar_ff  <= mar_in;
         rsp_bad_ff  <= ctl.invalid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bytes_used = rsp_used_ff;
   assign rsp_acc_value  = rsp_acc_ff;
   assign rsp_mar_value  = rsp_mar_ff;
   assign rsp_invalid_op = rsp_bad_ff;

   `LSUAM_ASSERT_IMP(a_no_accept_in_clear, clock, reset, clear_active_ff, !req_ready,
      "request accepted during memory clearing pass")
   `LSUAM_ASSERT_NXT(a_accept_starts_access, clock, reset, accept,
      s1_valid_ff && !phase_ff, "accepted request did not enter access phase")
   `LSUAM_ASSERT_NXT(a_access_advances, clock, reset, access,
      s1_valid_ff && phase_ff, "access phase did not advance")
   `LSUAM_ASSERT_IMP(a_phase_needs_request, clock, reset, phase_ff, s1_valid_ff,
      "second phase without a held request")

endmodule

`default_nettype wire
